// File: sv/gfg_pkg.sv
// Package for the gaze fixation grouper: sample record type, field widths,
// configuration register indexes and reset values.
// No dependencies; used by gfg_store, the grouper unit and the testbench.
package gfg_pkg;

  localparam int COORD_W = 12;
  localparam int TIME_W  = 32;
  localparam int LIMIT_W = 12;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd10;

  // Register index taken from the APB word address.
  localparam logic REG_DISTANCE_LIMIT = 1'b0;

  typedef struct packed {
    logic [TIME_W-1:0]  sample_time;
    logic [COORD_W-1:0] y_coord;
    logic [COORD_W-1:0] x_coord;
  } sample_t;

endpackage

// File: sv/gfg_div.sv
// Shared restoring divider for the gaze fixation grouper, one quotient bit per cycle.
// Standalone; used by gaze_fixation_grouper_unit for the running means.
module gfg_div #(
  parameter int DW = 19,
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int NW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [DW-1:0] quo;
  logic [VW-1:0] dsr;
  logic [NW-1:0] cnt;
  logic          busy;
  logic [VW:0]   shifted;
  logic          fits;

  assign shifted  = {rem, quo[DW-1]};
  assign fits     = shifted >= {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= NW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= VW'(shifted - {1'b0, dsr});
      end else begin
        rem <= shifted[VW-1:0];
      end
      quo <= {quo[DW-2:0], fits};
    end
  end

endmodule

// File: sv/gfg_store.sv
// Sample store of the gaze fixation grouper: one write port, one registered read port.
// Depends on gfg_pkg for the sample record.
module gfg_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  gfg_pkg::sample_t wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output gfg_pkg::sample_t rd_data
);

  import gfg_pkg::*;

  sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/gaze_fixation_grouper_unit.sv
// Gaze fixation grouper: one sample at a time and one result request for each. A
// sample joins at once, replaces a lone stored sample, joins after the oldest is tested
// away, or completes the fixation after both tests or when the store is full; the
// shared divider computes the means for every path that stores the sample.
// Reset is synchronous, clears the fixation and sets the limit to 10; the store is not cleared.
module gaze_fixation_grouper_unit #(
  parameter int MAX_SAMPLES = 64
) (
  input  logic             clk,
  input  logic             rst,
  // APB configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Sample requests
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [55:0]      s_tdata,   // x_coord, y_coord, sample_time
  // Result requests
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [95:0]      m_tdata,   // center_x, center_y, start_time, end_time, sample_count
  output logic [1:0]       m_tuser    // joined, fixation_done
);

  import gfg_pkg::*;

  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int SW = COORD_W + CW;

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_SQX      = 5'd1;
  localparam logic [4:0] ST_SQY      = 5'd2;
  localparam logic [4:0] ST_SQL      = 5'd3;
  localparam logic [4:0] ST_CMP      = 5'd4;
  localparam logic [4:0] ST_RDOLD    = 5'd5;
  localparam logic [4:0] ST_GETOLD   = 5'd6;
  localparam logic [4:0] ST_DIVX_GO  = 5'd7;
  localparam logic [4:0] ST_DIVX_W   = 5'd8;
  localparam logic [4:0] ST_DIVY_GO  = 5'd9;
  localparam logic [4:0] ST_DIVY_W   = 5'd10;
  localparam logic [4:0] ST_DROP     = 5'd11;
  localparam logic [4:0] ST_APPEND   = 5'd12;
  localparam logic [4:0] ST_MEANX_GO = 5'd13;
  localparam logic [4:0] ST_MEANX_W  = 5'd14;
  localparam logic [4:0] ST_MEANY_GO = 5'd15;
  localparam logic [4:0] ST_MEANY_W  = 5'd16;
  localparam logic [4:0] ST_SWEEP    = 5'd17;
  localparam logic [4:0] ST_SWEEPEND = 5'd18;
  localparam logic [4:0] ST_FINISH   = 5'd19;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [AW:0] s;
    s = (AW+1)'(base) + (AW+1)'(off);
    if (s >= (AW+1)'(MAX_SAMPLES)) begin
      s = s - (AW+1)'(MAX_SAMPLES);
    end
    return s[AW-1:0];
  endfunction

  logic [4:0]         state;
  logic [LIMIT_W-1:0] distance_limit;
  logic [AW-1:0]      head_index;
  logic [CW-1:0]      fill_count;
  logic [SW-1:0]      sum_x;
  logic [SW-1:0]      sum_y;
  logic [COORD_W-1:0] mean_x;
  logic [COORD_W-1:0] mean_y;

  sample_t            cur;
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic               second_test;
  logic [24:0]        dist_acc;
  logic [23:0]        limit_sq;
  logic [COORD_W-1:0] old_x;
  logic [COORD_W-1:0] old_y;
  logic [CW-1:0]      sweep_cnt;
  logic [TIME_W-1:0]  lo;
  logic [TIME_W-1:0]  hi;

  logic               done_flag;
  logic [COORD_W-1:0] rep_cx;
  logic [COORD_W-1:0] rep_cy;
  logic [TIME_W-1:0]  rep_lo;
  logic [TIME_W-1:0]  rep_hi;
  logic [CW-1:0]      rep_cnt;

  logic               out_joined;
  logic               out_done;
  logic [COORD_W-1:0] out_cx;
  logic [COORD_W-1:0] out_cy;
  logic [TIME_W-1:0]  out_lo;
  logic [TIME_W-1:0]  out_hi;
  logic [CW-1:0]      out_cnt;

  logic               cfg_write;
  logic               s_accept;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [COORD_W-1:0] mult_a;
  logic [23:0]        prod;
  logic [TIME_W-1:0]  t_rd;
  logic [TIME_W-1:0]  lo_upd;
  logic [TIME_W-1:0]  hi_upd;

  logic               div_start;
  logic [SW-1:0]      div_dividend;
  logic [CW-1:0]      div_divisor;
  logic               div_done;
  logic [SW-1:0]      div_quotient;

  logic               wr_en;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  sample_t            rd_data;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_DISTANCE_LIMIT);
  assign prdata    = (paddr[2] == REG_DISTANCE_LIMIT) ? 32'(distance_limit) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      distance_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  // Streams.
  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign m_tdata  = {1'b0, 7'(out_cnt), out_hi, out_lo, out_cy, out_cx};
  assign m_tuser  = {out_done, out_joined};

  // Distance test datapath, one squaring per cycle.
  assign dx     = (cx > cur.x_coord) ? cx - cur.x_coord : cur.x_coord - cx;
  assign dy     = (cy > cur.y_coord) ? cy - cur.y_coord : cur.y_coord - cy;
  assign mult_a = (state == ST_SQX) ? dx : (state == ST_SQY) ? dy : distance_limit;
  assign prod   = mult_a * mult_a;

  // Timestamp extremes during the sweep.
  assign t_rd   = rd_data.sample_time;
  assign lo_upd = (t_rd < lo) ? t_rd : lo;
  assign hi_upd = (t_rd > hi) ? t_rd : hi;

  // Divider operands.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = sum_x;
    div_divisor  = fill_count;
    case (state)
      ST_DIVX_GO: begin
        div_start    = 1'b1;
        div_dividend = sum_x - SW'(old_x);
        div_divisor  = fill_count - 1'b1;
      end
      ST_DIVY_GO: begin
        div_start    = 1'b1;
        div_dividend = sum_y - SW'(old_y);
        div_divisor  = fill_count - 1'b1;
      end
      ST_MEANX_GO: begin
        div_start = 1'b1;
      end
      ST_MEANY_GO: begin
        div_start    = 1'b1;
        div_dividend = sum_y;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Store access.
  assign wr_en = (state == ST_APPEND);
  assign rd_en = (state == ST_RDOLD) || ((state == ST_SWEEP));
  assign rd_addr = (state == ST_SWEEP) ? slot(head_index, sweep_cnt) : head_index;

  gfg_div #(
    .DW(SW),
    .VW(CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  gfg_store #(
    .DEPTH(MAX_SAMPLES),
    .AW   (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot(head_index, fill_count)),
    .wr_data (cur),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer and fixation state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head_index <= '0;
      fill_count <= '0;
      sum_x      <= '0;
      sum_y      <= '0;
      mean_x     <= '0;
      mean_y     <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            cur         <= sample_t'(s_tdata);
            cx          <= mean_x;
            cy          <= mean_y;
            second_test <= 1'b0;
            done_flag   <= 1'b0;
            rep_cx      <= '0;
            rep_cy      <= '0;
            rep_lo      <= '0;
            rep_hi      <= '0;
            rep_cnt     <= '0;
            sweep_cnt   <= '0;
            lo          <= '1;
            hi          <= '0;
            if (fill_count == '0) begin
              state <= ST_APPEND;
            end else if (fill_count == CW'(MAX_SAMPLES)) begin
              state <= ST_SWEEP;
            end else begin
              state <= ST_SQX;
            end
          end
        end
        ST_SQX: begin
          dist_acc <= 25'(prod);
          state    <= ST_SQY;
        end
        ST_SQY: begin
          dist_acc <= dist_acc + 25'(prod);
          state    <= ST_SQL;
        end
        ST_SQL: begin
          limit_sq <= prod;
          state    <= ST_CMP;
        end
        ST_CMP: begin
          if (dist_acc <= 25'(limit_sq)) begin
            state <= second_test ? ST_DROP : ST_APPEND;
          end else if (!second_test) begin
            state <= ST_RDOLD;
          end else begin
            state <= ST_SWEEP;
          end
        end
        ST_RDOLD: begin
          state <= ST_GETOLD;
        end
        ST_GETOLD: begin
          old_x <= rd_data.x_coord;
          old_y <= rd_data.y_coord;
          state <= (fill_count == CW'(1)) ? ST_DROP : ST_DIVX_GO;
        end
        ST_DIVX_GO: begin
          state <= ST_DIVX_W;
        end
        ST_DIVX_W: begin
          if (div_done) begin
            cx    <= div_quotient[COORD_W-1:0];
            state <= ST_DIVY_GO;
          end
        end
        ST_DIVY_GO: begin
          state <= ST_DIVY_W;
        end
        ST_DIVY_W: begin
          if (div_done) begin
            cy          <= div_quotient[COORD_W-1:0];
            second_test <= 1'b1;
            state       <= ST_SQX;
          end
        end
        ST_DROP: begin
          sum_x      <= sum_x - SW'(old_x);
          sum_y      <= sum_y - SW'(old_y);
          head_index <= slot(head_index, CW'(1));
          fill_count <= fill_count - 1'b1;
          state      <= ST_APPEND;
        end
        ST_APPEND: begin
          fill_count <= fill_count + 1'b1;
          sum_x      <= sum_x + SW'(cur.x_coord);
          sum_y      <= sum_y + SW'(cur.y_coord);
          state      <= ST_MEANX_GO;
        end
        ST_MEANX_GO: begin
          state <= ST_MEANX_W;
        end
        ST_MEANX_W: begin
          if (div_done) begin
            mean_x <= div_quotient[COORD_W-1:0];
            state  <= ST_MEANY_GO;
          end
        end
        ST_MEANY_GO: begin
          state <= ST_MEANY_W;
        end
        ST_MEANY_W: begin
          if (div_done) begin
            mean_y <= div_quotient[COORD_W-1:0];
            state  <= ST_FINISH;
          end
        end
        ST_SWEEP: begin
          if (sweep_cnt != '0) begin
            lo <= lo_upd;
            hi <= hi_upd;
          end
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == fill_count - 1'b1) begin
            state <= ST_SWEEPEND;
          end
        end
        ST_SWEEPEND: begin
          rep_lo     <= lo_upd;
          rep_hi     <= hi_upd;
          rep_cx     <= mean_x;
          rep_cy     <= mean_y;
          rep_cnt    <= fill_count;
          done_flag  <= 1'b1;
          head_index <= '0;
          fill_count <= '0;
          sum_x      <= '0;
          sum_y      <= '0;
          state      <= ST_APPEND;
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_joined <= !done_flag;
            out_done   <= done_flag;
            out_cx     <= rep_cx;
            out_cy     <= rep_cy;
            out_lo     <= rep_lo;
            out_hi     <= rep_hi;
            out_cnt    <= rep_cnt;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: verif/tb_gaze_fixation_grouper_unit.sv
// Self-checking testbench for gaze_fixation_grouper_unit: gaze samples go in on the
// sample stream, and every result request is checked against an in-bench fixation model.
// Depends on gfg_pkg and the grouper RTL only.
module tb_gaze_fixation_grouper_unit;
  import gfg_pkg::*;

  localparam int DEPTH = 64;
  localparam int OUT_W = 96;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] LIMIT_ADDR = {REG_DISTANCE_LIMIT, 2'b00};
  localparam logic [2:0] SPARE_ADDR = {~REG_DISTANCE_LIMIT, 2'b00};

  typedef struct packed {
    logic              joined;
    logic              fixation_done;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [TIME_W-1:0]  start_time;
    logic [TIME_W-1:0]  end_time;
    logic [6:0]         sample_count;
  } fixation_report_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [55:0]      s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [1:0]       m_tuser;

  gaze_fixation_grouper_unit #(.MAX_SAMPLES(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Fixation model state.
  logic [COORD_W-1:0] held_x [DEPTH];
  logic [COORD_W-1:0] held_y [DEPTH];
  logic [TIME_W-1:0]  held_time [DEPTH];
  int unsigned        oldest, held_count, total_x, total_y, centre_x, centre_y;
  logic [LIMIT_W-1:0] limit_q = LIMIT_RESET;

  fixation_report_t fixation_expected[$];
  int               mismatch_count = 0;
  int               tx_idle_pct = 0;
  int               rx_stall_pct = 0;
  int               hold_len = 0;
  int               hold_left = 0;
  int               quiet_cycles = 0;
  logic [TIME_W-1:0] clock_ms = '0;

  function automatic bit close_enough(int unsigned cx, int unsigned cy, int unsigned x,
                                      int unsigned y);
    longint unsigned dx, dy, lim;
    dx = (cx > x) ? cx - x : x - cx;
    dy = (cy > y) ? cy - y : y - cy;
    lim = limit_q;
    return dx * dx + dy * dy <= lim * lim;
  endfunction

  function automatic void refresh_centre();
    centre_x = (held_count != 0) ? total_x / held_count : 0;
    centre_y = (held_count != 0) ? total_y / held_count : 0;
  endfunction

  function automatic void store_sample(sample_t smp);
    int unsigned p;
    p = (oldest + held_count) % DEPTH;
    held_x[p] = smp.x_coord;
    held_y[p] = smp.y_coord;
    held_time[p] = smp.sample_time;
    held_count++;
    total_x += smp.x_coord;
    total_y += smp.y_coord;
    refresh_centre();
  endfunction

  function automatic void discard_oldest();
    total_x -= held_x[oldest];
    total_y -= held_y[oldest];
    oldest = (oldest + 1) % DEPTH;
    held_count--;
    refresh_centre();
  endfunction

  function automatic void clear_fixation();
    oldest = 0;
    held_count = 0;
    total_x = 0;
    total_y = 0;
    centre_x = 0;
    centre_y = 0;
  endfunction

  function automatic fixation_report_t predict_fixation(sample_t smp);
    fixation_report_t r;
    int unsigned rest_x, rest_y, i;
    logic [TIME_W-1:0] lo, hi, t;
    r = '0;
    if (held_count == 0) begin
      store_sample(smp);
      r.joined = 1'b1;
      return r;
    end
    if (held_count < DEPTH) begin
      if (close_enough(centre_x, centre_y, smp.x_coord, smp.y_coord)) begin
        store_sample(smp);
        r.joined = 1'b1;
        return r;
      end
      if (held_count == 1) begin
        discard_oldest();
        store_sample(smp);
        r.joined = 1'b1;
        return r;
      end
      rest_x = (total_x - held_x[oldest]) / (held_count - 1);
      rest_y = (total_y - held_y[oldest]) / (held_count - 1);
      if (close_enough(rest_x, rest_y, smp.x_coord, smp.y_coord)) begin
        discard_oldest();
        store_sample(smp);
        r.joined = 1'b1;
        return r;
      end
    end
    lo = '1;
    hi = '0;
    for (i = 0; i < held_count; i++) begin
      t = held_time[(oldest + i) % DEPTH];
      if (t < lo) lo = t;
      if (t > hi) hi = t;
    end
    r.fixation_done = 1'b1;
    r.center_x = centre_x[COORD_W-1:0];
    r.center_y = centre_y[COORD_W-1:0];
    r.start_time = lo;
    r.end_time = hi;
    r.sample_count = held_count[6:0];
    clear_fixation();
    store_sample(smp);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatch_count < 40)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    fixation_report_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.joined = m_tuser[0];
      got.fixation_done = m_tuser[1];
      got.center_x = m_tdata[11:0];
      got.center_y = m_tdata[23:12];
      got.start_time = m_tdata[55:24];
      got.end_time = m_tdata[87:56];
      got.sample_count = m_tdata[94:88];
      if (fixation_expected.size() == 0) begin
        report_mismatch("unexpected result request", m_tdata[63:0], 0);
      end else begin
        want = fixation_expected.pop_front();
        if (got.joined !== want.joined)
          report_mismatch("joined", got.joined, want.joined);
        if (got.fixation_done !== want.fixation_done)
          report_mismatch("fixation_done", got.fixation_done, want.fixation_done);
        if (got.center_x !== want.center_x)
          report_mismatch("center_x", got.center_x, want.center_x);
        if (got.center_y !== want.center_y)
          report_mismatch("center_y", got.center_y, want.center_y);
        if (got.start_time !== want.start_time)
          report_mismatch("start_time", got.start_time, want.start_time);
        if (got.end_time !== want.end_time)
          report_mismatch("end_time", got.end_time, want.end_time);
        if (got.sample_count !== want.sample_count)
          report_mismatch("sample_count", got.sample_count, want.sample_count);
      end
    end
  end

  // A long hold-off is requested by the test sequence and counted down here.
  always @(negedge clk) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len = 0;
    end
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_gaze_fixation_grouper_unit: done, errors");
      $finish;
    end
  end

  task automatic push_sample(input sample_t smp);
    @(negedge clk);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= smp;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    fixation_expected.push_back(predict_fixation(smp));
  endtask

  task automatic push_xyt(input int x, input int y, input logic [TIME_W-1:0] t);
    sample_t smp;
    smp.x_coord = x[COORD_W-1:0];
    smp.y_coord = y[COORD_W-1:0];
    smp.sample_time = t;
    push_sample(smp);
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (fixation_expected.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_check_limit();
    logic [31:0] value;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= LIMIT_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    value = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (value[LIMIT_W-1:0] !== limit_q)
      report_mismatch("distance_limit read", value[LIMIT_W-1:0], limit_q);
  endtask

  task automatic apply_limit(input logic [31:0] word);
    wait_results_done();
    apb_write(LIMIT_ADDR, word);
    limit_q = word[LIMIT_W-1:0];
    apb_check_limit();
  endtask

  function automatic int jitter(int r);
    return int'($urandom_range(2 * r)) - r;
  endfunction

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  function automatic logic [TIME_W-1:0] next_stamp();
    if ($urandom_range(99) < 8) return $urandom;
    clock_ms = clock_ms + $urandom_range(1, 40);
    return clock_ms;
  endfunction

  task automatic run_traffic(input int n_items);
    int sent, len, cx, cy, sp, k;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        push_xyt($urandom_range(4095), $urandom_range(4095), $urandom);
        sent++;
      end else begin
        cx = $urandom_range(4095);
        cy = $urandom_range(4095);
        sp = int'(limit_q) / 2;
        if ($urandom_range(4) == 0) sp = int'(limit_q) * 2 + 1;
        len = ($urandom_range(24) == 0) ? $urandom_range(64, 72) : $urandom_range(1, 24);
        if ($urandom_range(19) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(500);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(3) == 0) begin
            cx = clamp_coord(cx + jitter(sp / 2 + 1));
            cy = clamp_coord(cy + jitter(sp / 2 + 1));
          end
          push_xyt(clamp_coord(cx + jitter(sp)), clamp_coord(cy + jitter(sp)), next_stamp());
          sent++;
        end
      end
    end
  endtask

  task automatic test_reset_value();
    apb_check_limit();
  endtask

  task automatic test_directed();
    push_xyt(0, 0, 32'h0);
    push_xyt(0, 0, 32'hFFFF_FFFF);
    push_xyt(4095, 4095, 32'd5);
    push_xyt(100, 100, 32'd10);
    push_xyt(108, 100, 32'd11);
    push_xyt(116, 100, 32'd12);
    push_xyt(110, 106, 32'd13);
    push_xyt(500, 4095, 32'd14);
    push_xyt(4095, 0, 32'd20);
    push_xyt(4090, 6, 32'd21);
    push_xyt(4095, 10, 32'd22);
    push_xyt(0, 4095, 32'd7);
    push_xyt(6, 4087, 32'd3);
    push_xyt(14, 4091, 32'd9);
    push_xyt(2730, 1365, 32'hAAAA_5555);
    push_xyt(1365, 2730, 32'h5555_AAAA);
    wait_results_done();
    // A write beyond the register list must leave the limit alone.
    apb_write(SPARE_ADDR, 32'd77);
    apb_check_limit();
  endtask

  task automatic test_store_full();
    int k;
    apply_limit(32'd0);
    for (k = 0; k < DEPTH + 1; k++) push_xyt(2048, 2048, 32'd1000 + k);
    push_xyt(2048, 2049, 32'd2000);
    apply_limit(32'd4095);
    push_xyt(0, 0, 32'd1);
    push_xyt(0, 0, 32'd2);
    push_xyt(4095, 4095, 32'd3);
    push_xyt(4095, 0, 32'd4);
    push_xyt(0, 4095, 32'd5);
  endtask

  task automatic test_backpressure();
    int k;
    hold_len = 600;
    for (k = 0; k < 30; k++)
      push_xyt(1000 + jitter(300), 3000 + jitter(300), next_stamp());
    wait_results_done();
  endtask

  task automatic test_idling_phases();
    apply_limit(32'd10);
    run_traffic(300);

    tx_idle_pct = 84;
    apply_limit(32'd4095);
    run_traffic(250);

    tx_idle_pct = 0;
    rx_stall_pct = 84;
    apply_limit({20'($urandom_range(1048575)), 12'd0} | 32'($urandom_range(1, 300)));
    run_traffic(250);

    tx_idle_pct = 36;
    rx_stall_pct = 36;
    apply_limit(32'd0);
    run_traffic(100);
    apply_limit(32'd1);
    run_traffic(150);
  endtask

  initial begin
    clear_fixation();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_value();
    test_directed();
    test_store_full();
    test_backpressure();
    test_idling_phases();

    wait_results_done();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_gaze_fixation_grouper_unit: done, clean");
    end else begin
      $display("tb_gaze_fixation_grouper_unit: done, errors");
    end
    $finish;
  end

endmodule
